/* rtl/sgb_pkg.sv */
// sgb_pkg: shared types, register indexes and the tap weight lookup
// used by the separable gaussian blur unit and its divider
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

   localparam logic [2:0] CSR_WIDTH     = 3'd0;
   localparam logic [2:0] CSR_HEIGHT    = 3'd1;
   localparam logic [2:0] CSR_TAPS      = 3'd2;
   localparam logic [2:0] CSR_TAPS_LOW  = 3'd3;
   localparam logic [2:0] CSR_TAPS_HIGH = 3'd4;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [15:0] tap_weight(input logic [63:0] low_word,
                                              input logic [63:0] high_word,
                                              input logic [7:0]  idx);
      logic [15:0] wt;
      wt = '0;
      case (idx)
         8'd0: wt = low_word[15:0];
         8'd1: wt = low_word[31:16];
         8'd2: wt = low_word[47:32];
         8'd3: wt = low_word[63:48];
         8'd4: wt = high_word[15:0];
         8'd5: wt = high_word[31:16];
         8'd6: wt = high_word[47:32];
         8'd7: wt = high_word[63:48];
         default: wt = '0;
      endcase
      return wt;
   endfunction

endpackage

`default_nettype wire

/* rtl/sgb_divider.sv */
// sgb_divider: restoring divider, one quotient bit per cycle
// depends on sgb_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module sgb_divider #(
   parameter int NUM_W = 45,
   parameter int DEN_W = 28
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [NUM_W-1:0]       numerator,
   input  wire logic [DEN_W-1:0]       denominator,
   output logic      [NUM_W-1:0]       quotient,
   output sgb_pkg::div_status_type     status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= numerator;
         den_ff <= denominator;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not go busy");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(1)) |=> done_ff)
      else $error("divider missed its done pulse");
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");

endmodule

`default_nettype wire

/* rtl/separable_gaussian_blur_unit.sv */
// Separable gaussian blur unit, streaming 8-bit pixels in raster order.
// Every request is handled by one sequencer around a shared 16x16 multiplier,
// an accumulator and a bit-serial divider (sgb_divider, one quotient bit per
// cycle, NUM_W = 45 bits at the default parameters). One filter result
// (row or column) runs set-up, then read, multiply and accumulate for each of
// 2*tap_count-1 kernel taps, then division and write-back.
// A pixel request runs at most one row result (at most tap_count at a row end) and
// then one column result if an output is due; a flush request runs one column
// result at most. Requests are stalled while a request is in work; a finished
// pixel waits in the output register, so the next request can start meanwhile.
// Depends on sgb_pkg and sgb_divider.
`timescale 1ns / 1ps
`default_nettype none

module separable_gaussian_blur_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_TAPS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_pixel_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_pixel_out,
   output logic [9:0]       rsp_out_column,
   output logic [9:0]       rsp_out_row,
   output logic             rsp_frame_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int HLINES = 2 * MAX_TAPS - 1;
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WD_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int SL_W   = (HLINES > 1) ? $clog2(HLINES) : 1;
   localparam int T_W    = $clog2(MAX_TAPS + 1);
   localparam int K_W    = $clog2(2 * MAX_TAPS);
   localparam int DW     = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
   localparam int ACC_W  = 32 + $clog2(2 * MAX_TAPS);
   localparam int NORM_W = 16 + $clog2(2 * MAX_TAPS);
   localparam int NUM_W  = ACC_W + 9;
   localparam int DEN_W  = NORM_W + 8;
   localparam int HL_DEPTH = HLINES * (2 ** COL_W);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_START = 12'b0000_0000_0010,
      S_SETUP = 12'b0000_0000_0100,
      S_READ  = 12'b0000_0000_1000,
      S_MUL   = 12'b0000_0001_0000,
      S_ACC   = 12'b0000_0010_0000,
      S_DIV   = 12'b0000_0100_0000,
      S_WAIT  = 12'b0000_1000_0000,
      S_STORE = 12'b0001_0000_0000,
      S_ADV   = 12'b0010_0000_0000,
      S_CHECK = 12'b0100_0000_0000,
      S_EMIT  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [10:0] cfg_width_ff;
   logic [10:0] cfg_height_ff;
   logic [3:0]  cfg_taps_ff;
   logic [63:0] cfg_low_ff;
   logic [63:0] cfg_high_ff;

   // position counters
   logic [COL_W-1:0] in_col_ff;
   logic [ROW_W-1:0] in_row_ff;
   logic [SL_W-1:0]  in_slot_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic [SL_W-1:0]  out_slot_ff;

   // sequencer working registers
   logic                  op_ff;
   logic [7:0]            pix_ff;
   logic                  col_mode_ff;
   logic [COL_W-1:0]      col_ff;
   logic [COL_W-1:0]      hi_ff;
   logic signed [DW-1:0]  base_ff;
   logic [K_W-1:0]        k_ff;
   logic [SL_W-1:0]       slot_ff;
   logic                  use_ff;
   logic [15:0]           wt_ff;
   logic [31:0]           prod_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [NORM_W-1:0]     norm_ff;
   logic [15:0]           res_ff;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_pixel_ff;
   logic [9:0] rsp_col_ff;
   logic [9:0] rsp_row_ff;
   logic       rsp_end_ff;

   // memories
   logic [7:0]  raw_mem [MAX_WIDTH];
   logic [15:0] hl_mem  [HL_DEPTH];
   logic [7:0]  raw_rd_ff;
   logic [15:0] hl_rd_ff;

   logic [WD_W-1:0]  w_cl;
   logic [ROW_W-1:0] h_cl;
   logic [T_W-1:0]   t_cl;
   logic [DW-1:0]    wd, hd, td;
   logic             row_open;
   logic             csr_fire;
   logic             csr_known;
   logic             req_fire;
   logic             rsp_free;

   logic signed [DW-1:0] pos;
   logic signed [DW-1:0] dk;
   logic [DW-1:0]        dk_abs;
   logic [DW-1:0]        limit;
   logic                 pos_use;
   logic                 last_tap;
   logic [15:0]          mul_b;

   logic [DW-1:0]  ci, lo_v, hi_v, center;
   logic           any_row;
   logic [SL_W:0]  slot_sub;
   logic [SL_W-1:0] slot_start;
   logic [DW-1:0]  nr, nc;
   logic           ready_out;
   logic           frame_last;

   logic [NUM_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   logic                      div_start;
   logic [NUM_W-1:0]          div_quo;
   sgb_pkg::div_status_type   div_status;

   // clamped configuration
   always_comb begin
      if (cfg_width_ff == 11'd0) begin
         w_cl = WD_W'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         w_cl = WD_W'(MAX_WIDTH);
      end else begin
         w_cl = WD_W'(cfg_width_ff);
      end
      if (cfg_height_ff == 11'd0) begin
         h_cl = ROW_W'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_HEIGHT)) begin
         h_cl = ROW_W'(MAX_HEIGHT);
      end else begin
         h_cl = ROW_W'(cfg_height_ff);
      end
      if (cfg_taps_ff == 4'd0) begin
         t_cl = T_W'(1);
      end else if (32'(cfg_taps_ff) > 32'(MAX_TAPS)) begin
         t_cl = T_W'(MAX_TAPS);
      end else begin
         t_cl = T_W'(cfg_taps_ff);
      end
   end

   assign wd = DW'(w_cl);
   assign hd = DW'(h_cl);
   assign td = DW'(t_cl);

   assign row_open  = DW'(in_row_ff) < hd;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE;
   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_known = csr_index == sgb_pkg::CSR_WIDTH || csr_index == sgb_pkg::CSR_HEIGHT ||
                      csr_index == sgb_pkg::CSR_TAPS || csr_index == sgb_pkg::CSR_TAPS_LOW ||
                      csr_index == sgb_pkg::CSR_TAPS_HIGH;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // tap walk
   assign pos     = base_ff + $signed(DW'(k_ff));
   assign dk      = $signed(DW'(k_ff)) - $signed(td - DW'(1));
   assign dk_abs  = dk[DW-1] ? DW'(-dk) : DW'(dk);
   assign limit   = col_mode_ff ? hd : wd;
   assign pos_use = !pos[DW-1] && (DW'(pos) < limit);
   assign last_tap = DW'(k_ff) == ((td << 1) - DW'(2));
   assign mul_b   = col_mode_ff ? hl_rd_ff : {8'd0, raw_rd_ff};

   // row results due after this pixel
   always_comb begin
      ci      = DW'(in_col_ff);
      lo_v    = '0;
      hi_v    = '0;
      any_row = 1'b1;
      if (ci == wd - DW'(1)) begin
         lo_v = (wd > td) ? wd - td : '0;
         hi_v = wd - DW'(1);
      end else if (ci >= td - DW'(1)) begin
         lo_v = ci - (td - DW'(1));
         hi_v = lo_v;
      end else begin
         any_row = 1'b0;
      end
   end

   assign center     = col_mode_ff ? DW'(out_row_ff) : DW'(col_ff);
   assign slot_sub   = {1'b0, out_slot_ff} - (SL_W + 1)'(t_cl - T_W'(1));
   assign slot_start = slot_sub[SL_W] ? SL_W'(slot_sub + (SL_W + 1)'(HLINES))
                                      : slot_sub[SL_W-1:0];

   // output readiness: newest window pixel already received
   always_comb begin
      nr = DW'(out_row_ff) + td - DW'(1);
      nc = DW'(out_col_ff) + td - DW'(1);
      if (nr > hd - DW'(1)) begin
         nr = hd - DW'(1);
      end
      if (nc > wd - DW'(1)) begin
         nc = wd - DW'(1);
      end
      ready_out = !row_open || (nr < DW'(in_row_ff)) ||
                  ((nr == DW'(in_row_ff)) && (nc < DW'(in_col_ff)));
   end

   assign frame_last = (DW'(out_row_ff) == hd - DW'(1)) && (DW'(out_col_ff) == wd - DW'(1));

   // divider operands
   always_comb begin
      if (col_mode_ff) begin
         div_num = NUM_W'(acc_ff) + NUM_W'({norm_ff, 7'd0});
         div_den = {norm_ff, 8'd0};
      end else begin
         div_num = NUM_W'({acc_ff, 8'd0}) + NUM_W'(norm_ff >> 1);
         div_den = DEN_W'(norm_ff);
      end
   end

   assign div_start = (state_ff == S_DIV) && (norm_ff != '0);

   sgb_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .quotient    (div_quo),
      .status      (div_status)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (op_ff == sgb_pkg::OP_PIXEL && row_open) begin
               state_in = any_row ? S_SETUP : S_ADV;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_SETUP: state_in = S_READ;
         S_READ:  state_in = S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC:   state_in = last_tap ? S_DIV : S_READ;
         S_DIV: begin
            if (norm_ff != '0) begin
               state_in = S_WAIT;
            end else begin
               state_in = col_mode_ff ? S_EMIT : S_STORE;
            end
         end
         S_WAIT: begin
            if (div_status.done) begin
               state_in = col_mode_ff ? S_EMIT : S_STORE;
            end
         end
         S_STORE: state_in = (col_ff == hi_ff) ? S_ADV : S_SETUP;
         S_ADV:   state_in = S_CHECK;
         S_CHECK: begin
            if (DW'(out_row_ff) < hd && ready_out) begin
               state_in = S_SETUP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cfg_width_ff  <= 11'd1024;
         cfg_height_ff <= 11'd1024;
         cfg_taps_ff   <= 4'd1;
         cfg_low_ff    <= 64'd65535;
         cfg_high_ff   <= 64'd0;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_slot_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         out_slot_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            case (csr_index)
               sgb_pkg::CSR_WIDTH:     cfg_width_ff  <= csr_data[10:0];
               sgb_pkg::CSR_HEIGHT:    cfg_height_ff <= csr_data[10:0];
               sgb_pkg::CSR_TAPS:      cfg_taps_ff   <= csr_data[3:0];
               sgb_pkg::CSR_TAPS_LOW:  cfg_low_ff    <= csr_data;
               sgb_pkg::CSR_TAPS_HIGH: cfg_high_ff   <= csr_data;
               default: ;
            endcase
            if (csr_known) begin
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               in_slot_ff  <= '0;
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               out_slot_ff <= '0;
            end
         end
         if (state_ff == S_ADV) begin
            if (DW'(in_col_ff) + DW'(1) >= wd) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + 1'b1;
               in_slot_ff <= (in_slot_ff == SL_W'(HLINES - 1)) ? '0 : in_slot_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (state_ff == S_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            if (frame_last) begin
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               in_slot_ff  <= '0;
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               out_slot_ff <= '0;
            end else if (DW'(out_col_ff) + DW'(1) >= wd) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + 1'b1;
               out_slot_ff <= (out_slot_ff == SL_W'(HLINES - 1)) ? '0 : out_slot_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_operation;
         pix_ff <= req_pixel_in;
      end
      if (state_ff == S_START) begin
         col_mode_ff <= 1'b0;
         col_ff      <= COL_W'(lo_v);
         hi_ff       <= COL_W'(hi_v);
      end
      if (state_ff == S_CHECK) begin
         col_mode_ff <= 1'b1;
      end
      if (state_ff == S_SETUP) begin
         base_ff <= $signed(center - (td - DW'(1)));
         k_ff    <= '0;
         slot_ff <= slot_start;
         acc_ff  <= '0;
         norm_ff <= '0;
      end
      if (state_ff == S_READ) begin
         use_ff <= pos_use;
         wt_ff  <= sgb_pkg::tap_weight(cfg_low_ff, cfg_high_ff, 8'(dk_abs));
      end
      if (state_ff == S_MUL) begin
         prod_ff <= wt_ff * mul_b;
      end
      if (state_ff == S_ACC) begin
         if (use_ff) begin
            acc_ff  <= acc_ff + ACC_W'(prod_ff);
            norm_ff <= norm_ff + NORM_W'(wt_ff);
         end
         k_ff    <= k_ff + 1'b1;
         slot_ff <= (slot_ff == SL_W'(HLINES - 1)) ? '0 : slot_ff + 1'b1;
      end
      if (state_ff == S_DIV && norm_ff == '0) begin
         res_ff <= '0;
      end
      if (state_ff == S_WAIT && div_status.done) begin
         res_ff <= div_quo[15:0];
      end
      if (state_ff == S_STORE) begin
         col_ff <= col_ff + 1'b1;
      end
      if (state_ff == S_EMIT && rsp_free) begin
         rsp_pixel_ff <= (res_ff > 16'd255) ? 8'hFF : res_ff[7:0];
         rsp_col_ff   <= 10'(out_col_ff);
         rsp_row_ff   <= 10'(out_row_ff);
         rsp_end_ff   <= frame_last;
      end
   end

   // raw row and row-pass line stores
   always_ff @(posedge clock) begin
      if (state_ff == S_START && op_ff == sgb_pkg::OP_PIXEL && row_open) begin
         raw_mem[in_col_ff] <= pix_ff;
      end
      raw_rd_ff <= raw_mem[pos[COL_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_STORE) begin
         hl_mem[{in_slot_ff, col_ff}] <= res_ff;
      end
      hl_rd_ff <= hl_mem[{slot_ff, out_col_ff}];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_end  = rsp_end_ff;

   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (req_stall && !csr_ready))
      else $error("request taken while busy");
   a_store_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |-> !col_mode_ff)
      else $error("line store written in column mode");
   a_emit_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> col_mode_ff)
      else $error("emit without column result");

endmodule

`default_nettype wire
